// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the shortest path relaxation engine.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/spr_pkg.sv
// Package of the shortest path relaxation engine: widths, codes, record types.
// Depends on nothing; imported by every module of the engine.
package spr_pkg;

  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned MAX_EDGES_DEF = 4096;

  localparam int unsigned NODE_W   = 10;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned COST_W   = 48;
  localparam int unsigned CFG_W    = 10;

  localparam logic signed [COST_W-1:0] COST_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [COST_W-1:0] COST_MIN = 48'sh8000_0000_0000;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET  = 10'd1;
  localparam logic [CFG_W-1:0] SOURCE_NODE_RESET = 10'd1;

  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_SOURCE_NODE = 1'b1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] node_count;
    logic [CFG_W-1:0] source_node;
  } cfg_t;

  typedef struct packed {
    logic [NODE_W-1:0]          from_node;
    logic [NODE_W-1:0]          to_node;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_rec_t;

  typedef struct packed {
    logic                     reached;
    logic signed [COST_W-1:0] cost;
  } cost_ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_CLEAR,
    ST_SEED,
    ST_FETCH,
    ST_EDGE,
    ST_EVAL,
    ST_REPORT
  } state_t;

endpackage

// File: rtl/spr_edge_ram.sv
// Edge memory: one write port, one read port with registered read data.
// Depends on spr_pkg for the edge record type.
module spr_edge_ram #(
  parameter int unsigned DEPTH = spr_pkg::MAX_EDGES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  spr_pkg::edge_rec_t wdata,
  input  logic [AW-1:0]      raddr,
  output spr_pkg::edge_rec_t rdata
);
  import spr_pkg::*;

  edge_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/spr_cost_ram.sv
// Cost memory: per node a reach mark and a cost; one write port, two read ports.
// Depends on spr_pkg for the cost entry type.
module spr_cost_ram #(
  parameter int unsigned DEPTH = spr_pkg::MAX_NODES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  spr_pkg::cost_ent_t wdata,
  input  logic [AW-1:0]      ra_addr,
  output spr_pkg::cost_ent_t ra_data,
  input  logic [AW-1:0]      rb_addr,
  output spr_pkg::cost_ent_t rb_data
);
  import spr_pkg::*;

  cost_ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// File: rtl/spr_seq.sv
// Sequencer and relaxation datapath: loads, queries, clearing pass and edge passes.
// Depends on spr_pkg; drives the edge and cost memories instantiated at the top level.
module spr_seq #(
  parameter int unsigned MAX_NODES = spr_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = spr_pkg::MAX_EDGES_DEF,
  parameter int unsigned NW        = $clog2(MAX_NODES),
  parameter int unsigned EW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int unsigned TW        = $clog2(MAX_EDGES + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spr_pkg::cfg_t                        cfg,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic                                 action,
  input  logic [spr_pkg::NODE_W-1:0]           from_node,
  input  logic [spr_pkg::NODE_W-1:0]           to_node,
  input  logic signed [spr_pkg::WEIGHT_W-1:0]  edge_weight,
  input  logic                                 last_edge,
  input  logic [spr_pkg::NODE_W-1:0]           query_node,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic                                 result_kind,
  output logic                                 negative_cycle,
  output logic                                 reachable,
  output logic signed [spr_pkg::COST_W-1:0]    path_cost,
  output logic                                 edge_we,
  output logic [EW-1:0]                        edge_waddr,
  output spr_pkg::edge_rec_t                   edge_wdata,
  output logic [EW-1:0]                        edge_raddr,
  input  spr_pkg::edge_rec_t                   edge_rdata,
  output logic                                 cost_we,
  output logic [NW-1:0]                        cost_waddr,
  output spr_pkg::cost_ent_t                   cost_wdata,
  output logic [NW-1:0]                        cost_ra_addr,
  output logic [NW-1:0]                        cost_rb_addr,
  input  spr_pkg::cost_ent_t                   cost_ra_data,
  input  spr_pkg::cost_ent_t                   cost_rb_data
);
  import spr_pkg::*;

  state_t state, state_next;

  logic [TW-1:0]     edge_total;
  logic [EW-1:0]     k;
  logic [CFG_W-1:0]  pass;
  logic [NW-1:0]     clr_idx;
  logic [NODE_W-1:0] q_node;
  logic              cycle_found;
  logic              has_run;

  logic              accept;
  logic              out_free;
  logic              result_load;
  logic              load_room;
  logic              src_ok;
  logic              a_ok;
  logic              b_ok;
  logic              q_ok;
  logic              hit;
  logic              final_pass;
  logic              last_k;
  logic              clr_last;
  logic              improve;
  logic signed [COST_W:0]   sum_ext;
  logic signed [COST_W-1:0] sum_sat;

  function automatic logic node_ok(logic [NODE_W-1:0] v, logic [CFG_W-1:0] n);
    return (v != '0) && (v <= n) && (32'(v) < 32'(MAX_NODES));
  endfunction

  assign accept      = item_valid && item_ready;
  assign out_free    = !result_valid || result_ready;
  assign result_load = ((state == ST_QUERY) || (state == ST_REPORT)) && out_free;
  assign load_room   = edge_total < TW'(MAX_EDGES);
  assign src_ok      = node_ok(cfg.source_node, cfg.node_count);
  assign a_ok        = node_ok(edge_rdata.from_node, cfg.node_count);
  assign b_ok        = node_ok(edge_rdata.to_node, cfg.node_count);
  assign q_ok        = node_ok(q_node, cfg.node_count);
  assign hit         = q_ok && has_run && cost_ra_data.reached;
  assign final_pass  = pass >= cfg.node_count;
  assign last_k      = (TW'(k) + TW'(1)) == edge_total;
  assign clr_last    = clr_idx == NW'(MAX_NODES - 1);

  assign sum_ext = $signed({{(COST_W + 1 - WEIGHT_W){edge_rdata.weight[WEIGHT_W-1]}},
                            edge_rdata.weight})
                 + $signed({cost_ra_data.cost[COST_W-1], cost_ra_data.cost});

  always_comb begin
    if (sum_ext[COST_W] != sum_ext[COST_W-1]) begin
      sum_sat = sum_ext[COST_W] ? COST_MIN : COST_MAX;
    end else begin
      sum_sat = sum_ext[COST_W-1:0];
    end
  end

  assign improve = a_ok && b_ok && cost_ra_data.reached &&
                   (!cost_rb_data.reached ||
                    (sum_ext < $signed({cost_rb_data.cost[COST_W-1], cost_rb_data.cost})));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_QUERY) begin
            state_next = ST_QUERY;
          end else if (last_edge) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_QUERY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = src_ok ? ST_SEED : ST_REPORT;
        end
      end
      ST_SEED: begin
        state_next = (edge_total != '0) ? ST_FETCH : ST_REPORT;
      end
      ST_FETCH: state_next = ST_EDGE;
      ST_EDGE:  state_next = ST_EVAL;
      ST_EVAL: begin
        state_next = (last_k && final_pass) ? ST_REPORT : ST_FETCH;
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready   = state == ST_IDLE;
    edge_we      = accept && (action == ACT_LOAD) && load_room;
    edge_waddr   = edge_total[EW-1:0];
    edge_wdata   = '{from_node: from_node, to_node: to_node, weight: edge_weight};
    edge_raddr   = k;
    cost_rb_addr = NW'(edge_rdata.to_node);
    cost_we      = 1'b0;
    cost_waddr   = clr_idx;
    cost_wdata   = '0;
    case (state)
      ST_IDLE:  cost_ra_addr = NW'(query_node);
      ST_QUERY: cost_ra_addr = NW'(q_node);
      default:  cost_ra_addr = NW'(edge_rdata.from_node);
    endcase
    case (state)
      ST_CLEAR: begin
        cost_we = 1'b1;
      end
      ST_SEED: begin
        cost_we    = 1'b1;
        cost_waddr = NW'(cfg.source_node);
        cost_wdata = '{reached: 1'b1, cost: '0};
      end
      ST_EVAL: begin
        cost_we    = improve && !final_pass;
        cost_waddr = NW'(edge_rdata.to_node);
        cost_wdata = '{reached: 1'b1, cost: sum_sat};
      end
      default: begin
        cost_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      edge_total   <= '0;
      cycle_found  <= 1'b0;
      has_run      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action == ACT_QUERY) begin
              q_node <= query_node;
            end else begin
              if (load_room) begin
                edge_total <= edge_total + TW'(1);
              end
              if (last_edge) begin
                clr_idx     <= '0;
                cycle_found <= 1'b0;
                has_run     <= 1'b1;
              end
            end
          end
        end
        ST_QUERY: begin
          if (out_free) begin
            result_kind    <= KIND_ANSWER;
            negative_cycle <= cycle_found;
            reachable      <= hit;
            path_cost      <= hit ? cost_ra_data.cost : '0;
          end
        end
        ST_CLEAR: begin
          clr_idx <= clr_idx + NW'(1);
        end
        ST_SEED: begin
          pass <= CFG_W'(1);
          k    <= '0;
        end
        ST_EVAL: begin
          if (improve && final_pass) begin
            cycle_found <= 1'b1;
          end
          if (last_k) begin
            k    <= '0;
            pass <= pass + CFG_W'(1);
          end else begin
            k <= k + EW'(1);
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            result_kind    <= KIND_REPORT;
            negative_cycle <= cycle_found;
            reachable      <= 1'b0;
            path_cost      <= '0;
            edge_total     <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/shortest_path_relaxation_engine_top.sv
// Load: no result, beats taken while idle. Query: ST_QUERY loads the result once the output is
// free; the next beat waits until then. Run (load with last_edge): all MAX_NODES cost entries
// are cleared, then, with the source in range, a seed and node_count passes over the stored
// edges, each with an edge read, cost reads and a write-back; the report waits for free output.
// Reset (synchronous, active high): edge count, cycle flag and output valid cleared,
// node_count and source_node set to 1; queries report unreached until a run completes.
`include "assert_macros.svh"

module shortest_path_relaxation_engine_top #(
  parameter int unsigned MAX_NODES = spr_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = spr_pkg::MAX_EDGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [spr_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                action,
  input  logic [spr_pkg::NODE_W-1:0]          from_node,
  input  logic [spr_pkg::NODE_W-1:0]          to_node,
  input  logic signed [spr_pkg::WEIGHT_W-1:0] edge_weight,
  input  logic                                last_edge,
  input  logic [spr_pkg::NODE_W-1:0]          query_node,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                result_kind,
  output logic                                negative_cycle,
  output logic                                reachable,
  output logic signed [spr_pkg::COST_W-1:0]   path_cost
);
  import spr_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned TW = $clog2(MAX_EDGES + 1);

  cfg_t      cfg;
  logic      edge_we;
  logic [EW-1:0] edge_waddr;
  logic [EW-1:0] edge_raddr;
  edge_rec_t edge_wdata;
  edge_rec_t edge_rdata;
  logic      cost_we;
  logic [NW-1:0] cost_waddr;
  logic [NW-1:0] cost_ra_addr;
  logic [NW-1:0] cost_rb_addr;
  cost_ent_t cost_wdata;
  cost_ent_t cost_ra_data;
  cost_ent_t cost_rb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count  <= NODE_COUNT_RESET;
      cfg.source_node <= SOURCE_NODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_COUNT:  cfg.node_count  <= cfg_data;
        REG_SOURCE_NODE: cfg.source_node <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  spr_seq #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .NW        (NW),
    .EW        (EW),
    .TW        (TW)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .action         (action),
    .from_node      (from_node),
    .to_node        (to_node),
    .edge_weight    (edge_weight),
    .last_edge      (last_edge),
    .query_node     (query_node),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_kind    (result_kind),
    .negative_cycle (negative_cycle),
    .reachable      (reachable),
    .path_cost      (path_cost),
    .edge_we        (edge_we),
    .edge_waddr     (edge_waddr),
    .edge_wdata     (edge_wdata),
    .edge_raddr     (edge_raddr),
    .edge_rdata     (edge_rdata),
    .cost_we        (cost_we),
    .cost_waddr     (cost_waddr),
    .cost_wdata     (cost_wdata),
    .cost_ra_addr   (cost_ra_addr),
    .cost_rb_addr   (cost_rb_addr),
    .cost_ra_data   (cost_ra_data),
    .cost_rb_data   (cost_rb_data)
  );

  spr_edge_ram #(
    .DEPTH (MAX_EDGES),
    .AW    (EW)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  spr_cost_ram #(
    .DEPTH (MAX_NODES),
    .AW    (NW)
  ) u_cost_ram (
    .clk     (clk),
    .we      (cost_we),
    .waddr   (cost_waddr),
    .wdata   (cost_wdata),
    .ra_addr (cost_ra_addr),
    .ra_data (cost_ra_data),
    .rb_addr (cost_rb_addr),
    .rb_data (cost_rb_data)
  );

  `SPR_ASSERT_SAME(a_cost_write_busy, clk, rst, cost_we, !item_ready)
  `SPR_ASSERT_SAME(a_edge_write_on_load, clk, rst, edge_we,
                   item_valid && item_ready && (action == ACT_LOAD))
  `SPR_ASSERT_NEXT(a_query_blocks, clk, rst,
                   item_valid && item_ready && (action == ACT_QUERY), !item_ready)

endmodule
